/* design/svc_pkg.sv */
// ---------------------------------------------------------------------------
// svc_pkg: shared types and constants of the stereo vari-mu compressor
// Payload structs, step codes of the sequencer, fixed-point constants and the
// sine table generator.
// ---------------------------------------------------------------------------
package svc_pkg;

   localparam int SAMPLE_BITS          = 24;
   localparam int SINE_TABLE_BITS_DEF  = 10;

   localparam int MAG_W     = 30;      // magnitude after makeup gain, Q.24
   localparam int SPEED_W   = 48;      // speed, Q24.24
   localparam int COEFF_W   = 31;      // coefficient, Q.30, at most 1.0
   localparam int THR_W     = 25;
   localparam int ROOT_W    = 32;
   localparam int SINE_W    = 31;

   localparam int DIV_NUM_W = 80;
   localparam int DIV_DEN_W = 48;
   localparam int DIV_Q_W   = 64;
   localparam int DIV_CNT_W = 7;

   localparam logic [63:0] ONE_Q16         = 64'd1 << 16;
   localparam logic [63:0] ONE_Q20         = 64'd1 << 20;
   localparam logic [63:0] ONE_Q24         = 64'd1 << 24;
   localparam logic [63:0] ONE_Q30         = 64'd1 << 30;
   localparam logic [63:0] SPEED_MAX       = (64'd1 << 48) - 64'd1;
   localparam logic [63:0] SPEED_RESET     = 64'd10000 << 24;
   localparam logic [63:0] HALF_PI_Q24     = 64'd26353589;
   localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
   localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;

   // division lengths in quotient bits
   localparam logic [DIV_CNT_W-1:0] DSTEPS_VARY = 7'd55;
   localparam logic [DIV_CNT_W-1:0] DSTEPS_ATT  = 7'd64;
   localparam logic [DIV_CNT_W-1:0] DSTEPS_REL  = 7'd55;
   localparam logic [DIV_CNT_W-1:0] DSTEPS_SPD  = 7'd79;

   // register indexes
   localparam logic [2:0] CSR_THRESHOLD   = 3'd0;
   localparam logic [2:0] CSR_MAKEUP_GAIN = 3'd1;
   localparam logic [2:0] CSR_RELEASE     = 3'd2;
   localparam logic [2:0] CSR_FASTEST     = 3'd3;
   localparam logic [2:0] CSR_MU_BLEND    = 3'd4;
   localparam logic [2:0] CSR_MU_SQUARE   = 3'd5;
   localparam logic [2:0] CSR_OUT_GAIN    = 3'd6;

   // sequencer steps
   localparam int STEP_W = 6;
   localparam logic [STEP_W-1:0] ST_IDLE     = 6'd0;
   localparam logic [STEP_W-1:0] ST_MUL_L    = 6'd1;
   localparam logic [STEP_W-1:0] ST_MUL_R    = 6'd2;
   localparam logic [STEP_W-1:0] ST_RND_R    = 6'd3;
   localparam logic [STEP_W-1:0] ST_SENSE    = 6'd4;
   localparam logic [STEP_W-1:0] ST_VARY_GO  = 6'd5;
   localparam logic [STEP_W-1:0] ST_VARY_WT  = 6'd6;
   localparam logic [STEP_W-1:0] ST_ATT_GO   = 6'd7;
   localparam logic [STEP_W-1:0] ST_ATT_WT   = 6'd8;
   localparam logic [STEP_W-1:0] ST_ATT_MUL  = 6'd9;
   localparam logic [STEP_W-1:0] ST_ADIV_GO  = 6'd10;
   localparam logic [STEP_W-1:0] ST_ADIV_WT  = 6'd11;
   localparam logic [STEP_W-1:0] ST_ADIV_GET = 6'd12;
   localparam logic [STEP_W-1:0] ST_REL1_GO  = 6'd13;
   localparam logic [STEP_W-1:0] ST_REL1_WT  = 6'd14;
   localparam logic [STEP_W-1:0] ST_REL2_GO  = 6'd15;
   localparam logic [STEP_W-1:0] ST_REL2_WT  = 6'd16;
   localparam logic [STEP_W-1:0] ST_REL_GET  = 6'd17;
   localparam logic [STEP_W-1:0] ST_SPD_MUL  = 6'd18;
   localparam logic [STEP_W-1:0] ST_SPD_GO   = 6'd19;
   localparam logic [STEP_W-1:0] ST_SPD_WT   = 6'd20;
   localparam logic [STEP_W-1:0] ST_SPD_GET  = 6'd21;
   localparam logic [STEP_W-1:0] ST_SHP_GO   = 6'd22;
   localparam logic [STEP_W-1:0] ST_SHP_WT   = 6'd23;
   localparam logic [STEP_W-1:0] ST_SHP_GET  = 6'd24;
   localparam logic [STEP_W-1:0] ST_BL1      = 6'd25;
   localparam logic [STEP_W-1:0] ST_BL2      = 6'd26;
   localparam logic [STEP_W-1:0] ST_BL3      = 6'd27;
   localparam logic [STEP_W-1:0] ST_CH_MUL   = 6'd28;
   localparam logic [STEP_W-1:0] ST_CH_OG    = 6'd29;
   localparam logic [STEP_W-1:0] ST_CH_Y     = 6'd30;
   localparam logic [STEP_W-1:0] ST_CH_IDX   = 6'd31;
   localparam logic [STEP_W-1:0] ST_CH_RA    = 6'd32;
   localparam logic [STEP_W-1:0] ST_CH_RB    = 6'd33;
   localparam logic [STEP_W-1:0] ST_CH_INT   = 6'd34;
   localparam logic [STEP_W-1:0] ST_CH_SIN   = 6'd35;
   localparam logic [STEP_W-1:0] ST_DONE     = 6'd36;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
   } svc_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } svc_rsp_type;

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic              load;
      logic              publish;
   } svc_cmd_type;

   typedef struct packed {
      logic above;
      logic div_done;
      logic sqrt_done;
      logic square_mode;
      logic ch_last;
   } svc_stat_type;

   // quarter-wave sine entry, Q.30, Taylor series up to x^13
   function automatic logic [SINE_W-1:0] sine_entry(input longint unsigned i,
                                                    input int unsigned tbits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned r;
      x  = (i * HALF_PI_Q30) >> tbits;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 156;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
      r  = (x * t) >> 30;
      return r[SINE_W-1:0];
   endfunction

endpackage

/* design/svc_divider.sv */
// ---------------------------------------------------------------------------
// svc_divider: bit-serial restoring divider
// One quotient bit per cycle; numerator arrives left aligned, step count set
// by the caller. Done stays high until the next start.
// ---------------------------------------------------------------------------
module svc_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [svc_pkg::DIV_NUM_W-1:0]      num,
   input  logic [svc_pkg::DIV_DEN_W-1:0]      den,
   input  logic [svc_pkg::DIV_CNT_W-1:0]      steps,
   output logic [svc_pkg::DIV_Q_W-1:0]        quot,
   output logic                               done
);
   import svc_pkg::*;

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   q_ff, q_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;
      trial   = {rem_ff, num_ff[DIV_NUM_W-1]};
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = steps;
         done_in = 1'b0;
      end else if (cnt_ff != '0) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(trial - {1'b0, den_ff});
            q_in   = {q_ff[DIV_Q_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
            q_in   = {q_ff[DIV_Q_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign quot = q_ff;
   assign done = done_ff;

endmodule

/* design/svc_sqrt.sv */
// ---------------------------------------------------------------------------
// svc_sqrt: digit-by-digit integer square root
// Floor square root of a 64-bit value, one root bit per cycle.
// ---------------------------------------------------------------------------
module svc_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [63:0]                    value,
   output logic [svc_pkg::ROOT_W-1:0]     root,
   output logic                           done
);
   import svc_pkg::*;

   logic [63:0]       val_ff, val_in;
   logic [35:0]       rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [35:0]       acc;
   logic [35:0]       trial;

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;
      acc     = {rem_ff[33:0], val_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'd32;
         done_in = 1'b0;
      end else if (cnt_ff != '0) begin
         val_in = val_ff << 2;
         if (acc >= trial) begin
            rem_in  = acc - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = acc;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 6'd1) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

/* design/svc_datapath.sv */
// ---------------------------------------------------------------------------
// svc_datapath: arithmetic of the compressor
// Config registers, state, one shared 32x32 multiplier, the divider and
// square-root units, and the quarter-wave sine table.
// ---------------------------------------------------------------------------
module svc_datapath #(
   parameter int TBITS = svc_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  svc_pkg::svc_cmd_type     cmd,
   output svc_pkg::svc_stat_type    stat,
   input  svc_pkg::svc_req_type     req_data,
   output svc_pkg::svc_rsp_type     rsp_data,
   input  logic                     csr_valid,
   input  logic [2:0]               csr_index,
   input  logic [31:0]              csr_data
);
   import svc_pkg::*;

   localparam int TAB_N = (1 << TBITS) + 1;
   localparam int IDX_W = TBITS + 1;
   localparam int SH    = SAMPLE_BITS - 9;
   localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(1 << TBITS);
   localparam logic [63:0] MAXMAG = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

   typedef logic [SINE_W-1:0] sine_tab_type [TAB_N];

   function automatic sine_tab_type build_sine();
      sine_tab_type t;
      for (int i = 0; i < TAB_N; i++) begin
         t[i] = sine_entry(longint'(i), TBITS);
      end
      return t;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine();

   // configuration
   logic [24:0] thr_cfg_ff, thr_cfg_in;
   logic [20:0] mg_ff, mg_in;
   logic [31:0] rel_ff, rel_in;
   logic [31:0] fast_ff, fast_in;
   logic [16:0] mu_ff, mu_in;
   logic        sq_ff, sq_in;
   logic [16:0] og_ff, og_in;

   // state
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic [31:0]        gain_ff, gain_in;

   // working registers
   logic                   neg_ff [2];
   logic                   neg_in [2];
   logic [SAMPLE_BITS-1:0] m_ff [2];
   logic [SAMPLE_BITS-1:0] m_in [2];
   logic [MAG_W-1:0]       mag_ff [2];
   logic [MAG_W-1:0]       mag_in [2];
   logic [SAMPLE_BITS-1:0] out_ff [2];
   logic [SAMPLE_BITS-1:0] out_in [2];
   logic [MAG_W-1:0]       sense_ff, sense_in;
   logic [SPEED_W-1:0]     s_ff, s_in;
   logic [COEFF_W-1:0]     c_ff, c_in;
   logic [THR_W-1:0]       thr_ff, thr_in;
   logic [COEFF_W-1:0]     target_ff, target_in;
   logic [ROOT_W-1:0]      att_ff, att_in;
   logic [COEFF_W-1:0]     shaped_ff, shaped_in;
   logic [63:0]            acc_ff, acc_in;
   logic [COEFF_W-1:0]     coef_ff, coef_in;
   logic                   over_ff, over_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [15:0]            frac_ff, frac_in;
   logic [SINE_W-1:0]      a_ff, a_in;
   logic [SINE_W-1:0]      b_ff, b_in;
   logic                   ch_ff, ch_in;
   logic [63:0]            prod_ff, prod_in;
   logic [SINE_W-1:0]      rom_q_ff;
   svc_rsp_type            rsp_ff, rsp_in;

   // unit hookup and scratch
   logic                   div_start;
   logic [DIV_NUM_W-1:0]   div_num;
   logic [DIV_DEN_W-1:0]   div_den;
   logic [DIV_CNT_W-1:0]   div_steps;
   logic [DIV_Q_W-1:0]     div_q;
   logic                   div_done;
   logic                   sq_start;
   logic [63:0]            sq_value;
   logic [ROOT_W-1:0]      sq_root;
   logic                   sq_done;
   logic [IDX_W-1:0]       rom_addr;
   logic [MAG_W-1:0]       mag_max;
   logic [63:0]            t0, t1, t2;
   logic [SAMPLE_BITS-1:0] vs;

   svc_divider u_div (
      .clock (clock), .reset (reset), .start (div_start), .num (div_num),
      .den (div_den), .steps (div_steps), .quot (div_q), .done (div_done)
   );

   svc_sqrt u_sqrt (
      .clock (clock), .reset (reset), .start (sq_start), .value (sq_value),
      .root (sq_root), .done (sq_done)
   );

   assign mag_max = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];

   always_comb begin
      thr_cfg_in = thr_cfg_ff;
      mg_in      = mg_ff;
      rel_in     = rel_ff;
      fast_in    = fast_ff;
      mu_in      = mu_ff;
      sq_in      = sq_ff;
      og_in      = og_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD:   thr_cfg_in = csr_data[24:0];
            CSR_MAKEUP_GAIN: mg_in      = csr_data[20:0];
            CSR_RELEASE:     rel_in     = csr_data;
            CSR_FASTEST:     fast_in    = csr_data;
            CSR_MU_BLEND:    mu_in      = csr_data[16:0];
            CSR_MU_SQUARE:   sq_in      = csr_data[0];
            CSR_OUT_GAIN:    og_in      = csr_data[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      speed_in  = speed_ff;
      gain_in   = gain_ff;
      neg_in    = neg_ff;
      m_in      = m_ff;
      mag_in    = mag_ff;
      out_in    = out_ff;
      sense_in  = sense_ff;
      s_in      = s_ff;
      c_in      = c_ff;
      thr_in    = thr_ff;
      target_in = target_ff;
      att_in    = att_ff;
      shaped_in = shaped_ff;
      acc_in    = acc_ff;
      coef_in   = coef_ff;
      over_in   = over_ff;
      idx_in    = idx_ff;
      frac_in   = frac_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      ch_in     = ch_ff;
      prod_in   = prod_ff;
      rsp_in    = rsp_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = s_ff;
      div_steps = DSTEPS_REL;
      sq_start  = 1'b0;
      sq_value  = 64'(s_ff) << 16;
      rom_addr  = (idx_ff == IDX_TOP) ? idx_ff : idx_ff + 1'b1;
      t0        = '0;
      t1        = '0;
      t2        = '0;
      vs        = '0;

      if (cmd.load) begin
         vs        = req_data.left_sample;
         neg_in[0] = vs[SAMPLE_BITS-1];
         m_in[0]   = vs[SAMPLE_BITS-1] ? -vs : vs;
         vs        = req_data.right_sample;
         neg_in[1] = vs[SAMPLE_BITS-1];
         m_in[1]   = vs[SAMPLE_BITS-1] ? -vs : vs;
         s_in      = (64'(speed_ff) < ONE_Q24) ? SPEED_W'(ONE_Q24) : speed_ff;
         c_in      = (64'(gain_ff) > ONE_Q30) ? COEFF_W'(ONE_Q30) : gain_ff[COEFF_W-1:0];
         thr_in    = (64'(thr_cfg_ff) > ONE_Q24) ? THR_W'(ONE_Q24) : thr_cfg_ff;
      end
      if (cmd.publish) begin
         rsp_in.left_out  = out_ff[0];
         rsp_in.right_out = out_ff[1];
      end

      case (cmd.step)
         ST_MUL_L: begin
            prod_in = 64'(32'(m_ff[0])) * 64'(32'(mg_ff));
         end
         ST_MUL_R: begin
            t0        = (prod_ff + (64'd1 << (SH - 1))) >> SH;
            mag_in[0] = t0[MAG_W-1:0];
            prod_in   = 64'(32'(m_ff[1])) * 64'(32'(mg_ff));
         end
         ST_RND_R: begin
            t0        = (prod_ff + (64'd1 << (SH - 1))) >> SH;
            mag_in[1] = t0[MAG_W-1:0];
         end
         ST_SENSE: begin
            sense_in = mag_max;
         end
         ST_VARY_GO: begin
            div_start = 1'b1;
            div_steps = DSTEPS_VARY;
            div_den   = DIV_DEN_W'(sense_ff);
            div_num   = (DIV_NUM_W'(thr_ff) << 30) << (DIV_NUM_W - int'(DSTEPS_VARY));
         end
         ST_ATT_GO: begin
            t0        = 64'(thr_ff) << 6;
            target_in = (div_q < t0) ? t0[COEFF_W-1:0] : div_q[COEFF_W-1:0];
            sq_start  = 1'b1;
            sq_value  = 64'(s_ff) << 16;
         end
         ST_ATT_MUL: begin
            att_in  = sq_root;
            prod_in = 64'(c_ff) * 64'(sq_root - ROOT_W'(ONE_Q20));
         end
         ST_ADIV_GO: begin
            t0        = prod_ff + (64'(target_ff) << 20);
            div_start = 1'b1;
            div_steps = DSTEPS_ATT;
            div_den   = DIV_DEN_W'(att_ff);
            div_num   = DIV_NUM_W'(t0) << (DIV_NUM_W - int'(DSTEPS_ATT));
         end
         ST_ADIV_GET: begin
            c_in = (div_q > ONE_Q30) ? COEFF_W'(ONE_Q30) : div_q[COEFF_W-1:0];
         end
         ST_REL1_GO: begin
            t0        = (ONE_Q30 - 64'(c_ff)) << 24;
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(t0) << (DIV_NUM_W - int'(DSTEPS_REL));
         end
         ST_REL2_GO: begin
            t0        = div_q << 24;
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(t0) << (DIV_NUM_W - int'(DSTEPS_REL));
         end
         ST_REL_GET: begin
            t0   = 64'(c_ff) + div_q;
            c_in = (t0 > ONE_Q30) ? COEFF_W'(ONE_Q30) : t0[COEFF_W-1:0];
         end
         ST_SPD_MUL: begin
            prod_in = 64'(sense_ff) * 64'(rel_ff);
         end
         ST_SPD_GO: begin
            t0        = (prod_ff >> 8) + (64'(fast_ff) << 8);
            div_start = 1'b1;
            div_steps = DSTEPS_SPD;
            div_num   = (DIV_NUM_W'(t0) << 24) << (DIV_NUM_W - int'(DSTEPS_SPD));
         end
         ST_SPD_GET: begin
            t1 = (div_q > (64'd1 << 48)) ? (64'd1 << 48) : div_q;
            t0 = 64'(s_ff) + t1;
            t2 = (t0 < (ONE_Q24 << 1)) ? ONE_Q24 : t0 - ONE_Q24;
            if (t2 > SPEED_MAX) begin
               t2 = SPEED_MAX;
            end
            speed_in = t2[SPEED_W-1:0];
            gain_in  = 32'(c_ff);
         end
         ST_SHP_GO: begin
            if (sq_ff) begin
               prod_in = 64'(c_ff) * 64'(c_ff);
            end else begin
               sq_start = 1'b1;
               sq_value = 64'(c_ff) << 30;
            end
         end
         ST_SHP_GET: begin
            t0        = prod_ff >> 30;
            shaped_in = sq_ff ? t0[COEFF_W-1:0] : COEFF_W'(sq_root);
         end
         ST_BL1: begin
            t1      = (64'(mu_ff) > ONE_Q16) ? ONE_Q16 : 64'(mu_ff);
            prod_in = 64'(shaped_ff) * t1;
         end
         ST_BL2: begin
            t1      = (64'(mu_ff) > ONE_Q16) ? ONE_Q16 : 64'(mu_ff);
            acc_in  = prod_ff;
            prod_in = 64'(c_ff) * (ONE_Q16 - t1);
         end
         ST_BL3: begin
            t0      = (acc_ff + prod_ff) >> 16;
            coef_in = t0[COEFF_W-1:0];
            ch_in   = 1'b0;
         end
         ST_CH_MUL: begin
            prod_in = 64'(mag_ff[ch_ff]) * 64'(coef_ff);
         end
         ST_CH_OG: begin
            t1      = (64'(og_ff) > ONE_Q16) ? ONE_Q16 : 64'(og_ff);
            t0      = prod_ff >> 30;
            prod_in = 64'(t0[31:0]) * t1;
         end
         ST_CH_Y: begin
            t0      = prod_ff >> 16;
            over_in = (64'(t0[31:0]) > HALF_PI_Q24);
            prod_in = 64'(t0[31:0]) * 64'(TWO_OVER_PI_Q32);
         end
         ST_CH_IDX: begin
            t0       = prod_ff >> (56 - TBITS);
            idx_in   = (t0 >= 64'(IDX_TOP)) ? IDX_TOP : t0[IDX_W-1:0];
            t1       = prod_ff >> (40 - TBITS);
            frac_in  = t1[15:0];
            rom_addr = idx_in;
         end
         ST_CH_RA: begin
            a_in = rom_q_ff;
         end
         ST_CH_RB: begin
            b_in = rom_q_ff;
         end
         ST_CH_INT: begin
            t1      = (b_ff >= a_ff) ? 64'(b_ff - a_ff) : 64'(a_ff - b_ff);
            prod_in = t1 * 64'(frac_ff);
         end
         ST_CH_SIN: begin
            t1 = prod_ff >> 16;
            t0 = (b_ff >= a_ff) ? 64'(a_ff) + t1 : 64'(a_ff) - t1;
            t2 = ((t0 << (SAMPLE_BITS - 1)) + (64'd1 << 29)) >> 30;
            if (over_ff || t2 > MAXMAG) begin
               t2 = MAXMAG;
            end
            vs            = t2[SAMPLE_BITS-1:0];
            out_in[ch_ff] = neg_ff[ch_ff] ? -vs : vs;
            ch_in         = ~ch_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      neg_ff    <= neg_in;
      m_ff      <= m_in;
      mag_ff    <= mag_in;
      out_ff    <= out_in;
      sense_ff  <= sense_in;
      s_ff      <= s_in;
      c_ff      <= c_in;
      thr_ff    <= thr_in;
      target_ff <= target_in;
      att_ff    <= att_in;
      shaped_ff <= shaped_in;
      acc_ff    <= acc_in;
      coef_ff   <= coef_in;
      over_ff   <= over_in;
      idx_ff    <= idx_in;
      frac_ff   <= frac_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      ch_ff     <= ch_in;
      prod_ff   <= prod_in;
      rsp_ff    <= rsp_in;
      rom_q_ff  <= SINE_TAB[rom_addr];
      if (reset) begin
         thr_cfg_ff <= 25'd16777216;
         mg_ff      <= 21'd65536;
         rel_ff     <= 32'd12325632;
         fast_ff    <= 32'd14380000;
         mu_ff      <= 17'd65536;
         sq_ff      <= 1'b1;
         og_ff      <= 17'd65536;
         speed_ff   <= SPEED_W'(SPEED_RESET);
         gain_ff    <= 32'(ONE_Q30);
      end else begin
         thr_cfg_ff <= thr_cfg_in;
         mg_ff      <= mg_in;
         rel_ff     <= rel_in;
         fast_ff    <= fast_in;
         mu_ff      <= mu_in;
         sq_ff      <= sq_in;
         og_ff      <= og_in;
         speed_ff   <= speed_in;
         gain_ff    <= gain_in;
      end
   end

   assign stat.above       = (mag_max > MAG_W'(thr_ff));
   assign stat.div_done    = div_done;
   assign stat.sqrt_done   = sq_done;
   assign stat.square_mode = sq_ff;
   assign stat.ch_last     = ch_ff;
   assign rsp_data         = rsp_ff;

endmodule

/* design/svc_controller.sv */
// ---------------------------------------------------------------------------
// svc_controller: step sequencer of the compressor
// Walks one item through the datapath and owns both handshakes.
// ---------------------------------------------------------------------------
module svc_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output svc_pkg::svc_cmd_type     cmd,
   input  svc_pkg::svc_stat_type    stat
);
   import svc_pkg::*;

   logic [STEP_W-1:0] state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              load;
   logic              publish;

   always_comb begin
      state_in = state_ff;
      load     = 1'b0;
      publish  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               load     = 1'b1;
               state_in = ST_MUL_L;
            end
         end
         ST_MUL_L:    state_in = ST_MUL_R;
         ST_MUL_R:    state_in = ST_RND_R;
         ST_RND_R:    state_in = ST_SENSE;
         ST_SENSE:    state_in = stat.above ? ST_VARY_GO : ST_REL1_GO;
         ST_VARY_GO:  state_in = ST_VARY_WT;
         ST_VARY_WT:  state_in = stat.div_done ? ST_ATT_GO : ST_VARY_WT;
         ST_ATT_GO:   state_in = ST_ATT_WT;
         ST_ATT_WT:   state_in = stat.sqrt_done ? ST_ATT_MUL : ST_ATT_WT;
         ST_ATT_MUL:  state_in = ST_ADIV_GO;
         ST_ADIV_GO:  state_in = ST_ADIV_WT;
         ST_ADIV_WT:  state_in = stat.div_done ? ST_ADIV_GET : ST_ADIV_WT;
         ST_ADIV_GET: state_in = ST_SPD_MUL;
         ST_REL1_GO:  state_in = ST_REL1_WT;
         ST_REL1_WT:  state_in = stat.div_done ? ST_REL2_GO : ST_REL1_WT;
         ST_REL2_GO:  state_in = ST_REL2_WT;
         ST_REL2_WT:  state_in = stat.div_done ? ST_REL_GET : ST_REL2_WT;
         ST_REL_GET:  state_in = ST_SPD_MUL;
         ST_SPD_MUL:  state_in = ST_SPD_GO;
         ST_SPD_GO:   state_in = ST_SPD_WT;
         ST_SPD_WT:   state_in = stat.div_done ? ST_SPD_GET : ST_SPD_WT;
         ST_SPD_GET:  state_in = ST_SHP_GO;
         ST_SHP_GO:   state_in = stat.square_mode ? ST_SHP_GET : ST_SHP_WT;
         ST_SHP_WT:   state_in = stat.sqrt_done ? ST_SHP_GET : ST_SHP_WT;
         ST_SHP_GET:  state_in = ST_BL1;
         ST_BL1:      state_in = ST_BL2;
         ST_BL2:      state_in = ST_BL3;
         ST_BL3:      state_in = ST_CH_MUL;
         ST_CH_MUL:   state_in = ST_CH_OG;
         ST_CH_OG:    state_in = ST_CH_Y;
         ST_CH_Y:     state_in = ST_CH_IDX;
         ST_CH_IDX:   state_in = ST_CH_RA;
         ST_CH_RA:    state_in = ST_CH_RB;
         ST_CH_RB:    state_in = ST_CH_INT;
         ST_CH_INT:   state_in = ST_CH_SIN;
         ST_CH_SIN:   state_in = stat.ch_last ? ST_DONE : ST_CH_MUL;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               publish  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
      rsp_valid_in = publish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.step    = state_ff;
   assign cmd.load    = load;
   assign cmd.publish = publish;

endmodule

/* design/stereo_varimu_compressor_core.sv */
// ---------------------------------------------------------------------------
// stereo_varimu_compressor_core: stereo vari-mu compressor with sine clip
// Top level: sequencer, datapath and the handshake ports.
// ---------------------------------------------------------------------------
// One item is a stereo pair of Q1.23 samples; one result pair comes back for
// each. The block works on one item at a time; how long an item takes is set
// by the bit-serial divider (one quotient bit a cycle; the 79-bit speed
// update runs for every item, below threshold two 55-bit release divides
// come on top, above it a 55- and a 64-bit divide) and the square-root unit
// (attack term, and the coefficient shaping when square mode is off).
// Shortest is below threshold in square mode, longest above threshold in
// root mode. A finished result waits in an output register, so the next
// item is taken while it is pending.
// Configuration writes are taken every cycle (csr_ready is always high) and
// should only be issued while the block is idle.
module stereo_varimu_compressor_core #(
   parameter int SINE_TABLE_BITS = svc_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  svc_pkg::svc_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output svc_pkg::svc_rsp_type  rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data
);
   import svc_pkg::*;

   svc_cmd_type  cmd;
   svc_stat_type stat;

   // registers can be written at any cycle
   assign csr_ready = 1'b1;

   svc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath holds config, speed/coefficient state and the sine table
   svc_datapath #(
      .TBITS (SINE_TABLE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // an accepted item always starts the magnitude step
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> cmd.step == ST_MUL_L)
      else $error("accepted item did not start the sequence");

   // a result only appears out of the final step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.step) == ST_DONE)
      else $error("result raised outside the final step");

   // no new item while one is at work
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.step != ST_IDLE |-> !req_ready)
      else $error("ready while busy");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the stereo vari-mu compressor core
// Sample pairs go in through a queue-fed driver and results are compared,
// field by field, against a bit-exact predictor kept in step with the block.
// Settings are changed between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb;
   import svc_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   svc_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   svc_rsp_type rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   stereo_varimu_compressor_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state and settings
   longint unsigned p_thr, p_makeup, p_release, p_fastest, p_blend, p_square, p_ogain;
   longint unsigned p_speed, p_coeff;
   logic [31:0]     sine_lut [0:1024];

   svc_req_type pending_pairs [$];
   svc_rsp_type expected_pairs [$];
   int  fail_count;
   int  cycle_count;
   int  hold_cycles;    // long receiver hold-off, counted down by the monitor
   int  sent_count;
   bit  req_taken;      // offered item was accepted at the last rising edge

   localparam int CYCLE_LIMIT = 4000000;

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   // -------------------------------------------------------------------
   // predictor arithmetic
   // -------------------------------------------------------------------
   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else
            r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   // min(floor(num*2^sh/den), cap), long division; cap < 2^62
   function automatic longint unsigned sat_quot(longint unsigned num, int sh,
                                                longint unsigned den,
                                                longint unsigned cap);
      longint unsigned r, q, b;
      if (den == 0) return cap;
      r = 0; q = 0;
      for (int i = 63 + sh; i >= 0; i--) begin
         b = (i >= sh) ? ((num >> (i - sh)) & 64'd1) : 64'd0;
         r = (r << 1) | b;
         q <<= 1;
         if (r >= den) begin
            r -= den;
            q |= 64'd1;
         end
         if (q > cap) return cap;
      end
      return q;
   endfunction

   function automatic longint unsigned quarter_sine(longint unsigned x);
      longint unsigned x2, t;
      longint unsigned dv [6];
      dv = '{156, 110, 72, 42, 20, 6};
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (int k = 0; k < 6; k++) t = ONE_Q30 - ((x2 * t) >> 30) / dv[k];
      return (x * t) >> 30;
   endfunction

   function automatic longint unsigned interp_sine(longint unsigned y);
      longint unsigned prod, idx, frac, a, b;
      prod = y * longint'(TWO_OVER_PI_Q32);
      idx  = prod >> 46;
      frac = (prod >> 30) & 64'hFFFF;
      if (idx >= 1024) return sine_lut[1024];
      a = sine_lut[idx];
      b = sine_lut[idx + 1];
      if (b >= a) return a + (((b - a) * frac) >> 16);
      return a - (((a - b) * frac) >> 16);
   endfunction

   function automatic logic [23:0] soft_clip(longint unsigned y, bit neg);
      longint unsigned mag, s;
      if (y > HALF_PI_Q24) mag = 64'h7FFFFF;
      else begin
         s   = interp_sine(y);
         mag = ((s << 23) + (64'd1 << 29)) >> 30;
         if (mag > 64'h7FFFFF) mag = 64'h7FFFFF;
      end
      return neg ? 24'(-mag) : 24'(mag);
   endfunction

   function automatic svc_rsp_type compress_pair(svc_req_type pair);
      longint unsigned mag [2];
      bit              neg [2];
      longint unsigned thr, s, c, sense, incr, d, ns, shaped, mu, og, coef, y;
      longint unsigned vary, target, att, q1;
      logic [23:0]     v;
      logic [23:0]     outs [2];
      svc_rsp_type     r;
      for (int ch = 0; ch < 2; ch++) begin
         v = (ch == 0) ? pair.left_sample : pair.right_sample;
         neg[ch] = v[23];
         mag[ch] = neg[ch] ? ((64'd1 << 24) - v) : v;
         mag[ch] = (mag[ch] * p_makeup + (64'd1 << 14)) >> 15;
      end
      sense = (mag[0] > mag[1]) ? mag[0] : mag[1];
      thr = (p_thr > ONE_Q24) ? ONE_Q24 : p_thr;
      s = p_speed;
      if (s < ONE_Q24) s = ONE_Q24;
      if (s > SPEED_MAX) s = SPEED_MAX;
      c = (p_coeff > ONE_Q30) ? ONE_Q30 : p_coeff;
      if (sense > thr) begin
         vary   = (thr << 30) / sense;
         target = (vary < (thr << 6)) ? (thr << 6) : vary;
         att    = root64(s << 16);
         c = (c * (att - ONE_Q20) + (target << 20)) / att;
      end else begin
         q1 = ((ONE_Q30 - c) << 24) / s;
         c  = c + ((q1 << 24) / s);
      end
      if (c > ONE_Q30) c = ONE_Q30;
      p_coeff = c;
      incr = ((sense * p_release) >> 8) + (p_fastest << 8);
      d  = sat_quot(incr, 24, s, 64'd1 << 48);
      ns = s + d;
      ns = (ns < 2 * ONE_Q24) ? ONE_Q24 : ns - ONE_Q24;
      if (ns > SPEED_MAX) ns = SPEED_MAX;
      p_speed = ns;
      shaped = p_square ? ((c * c) >> 30) : root64(c << 30);
      mu = (p_blend > ONE_Q16) ? ONE_Q16 : p_blend;
      og = (p_ogain > ONE_Q16) ? ONE_Q16 : p_ogain;
      coef = (shaped * mu + c * (ONE_Q16 - mu)) >> 16;
      for (int ch = 0; ch < 2; ch++) begin
         y = (mag[ch] * coef) >> 30;
         y = (y * og) >> 16;
         outs[ch] = soft_clip(y, neg[ch]);
      end
      r.left_out  = outs[0];
      r.right_out = outs[1];
      return r;
   endfunction

   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 400);
   endfunction

   // -------------------------------------------------------------------
   // driver: takes pending pairs, inserts random gaps, runs at negedge
   // -------------------------------------------------------------------
   int  send_gap;
   bit  pace_sender;    // off during stretches with no gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // item still offered, hold it
      end else begin
         if (req_valid) sent_count <= sent_count + 1;
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pending_pairs.size() > 0) begin
            req_data  <= pending_pairs.pop_front();
            req_valid <= 1'b1;
            send_gap  <= pace_sender ? gap_length() : 0;
         end else
            req_valid <= 1'b0;
      end
   end

   // the sample accepted at each edge is predicted right there, so the
   // predictor always sees items in handshake order
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         expected_pairs.push_back(compress_pair(req_data));
   end

   // -------------------------------------------------------------------
   // monitor: checks each result; drives rsp_ready at negedge
   // -------------------------------------------------------------------
   svc_rsp_type want;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pairs.size() == 0) begin
            $display("%0t: result with nothing expected, actual %h", $time, rsp_data);
            fail_count <= fail_count + 1;
         end else begin
            want = expected_pairs.pop_front();
            if (rsp_data.left_out !== want.left_out) begin
               $display("%0t: left_out expected %h actual %h",
                        $time, want.left_out, rsp_data.left_out);
               fail_count <= fail_count + 1;
            end
            if (rsp_data.right_out !== want.right_out) begin
               $display("%0t: right_out expected %h actual %h",
                        $time, want.right_out, rsp_data.right_out);
               fail_count <= fail_count + 1;
            end
         end
      end
   end

   int recv_gap;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (recv_gap > 0) begin
         rsp_ready <= 1'b0;
         recv_gap  <= recv_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_valid && rsp_ready && pace_sender) recv_gap <= gap_length();
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // -------------------------------------------------------------------
   // register writes (only while idle), mirrored into the predictor
   // -------------------------------------------------------------------
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_THRESHOLD:   p_thr     = value & 32'h1FFFFFF;
         CSR_MAKEUP_GAIN: p_makeup  = value & 32'h1FFFFF;
         CSR_RELEASE:     p_release = value;
         CSR_FASTEST:     p_fastest = value;
         CSR_MU_BLEND:    p_blend   = value & 32'h1FFFF;
         CSR_MU_SQUARE:   p_square  = value & 32'h1;
         CSR_OUT_GAIN:    p_ogain   = value & 32'h1FFFF;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_pairs.size() > 0 || req_valid || expected_pairs.size() > 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic add_pair(input logic [23:0] l, input logic [23:0] r);
      svc_req_type p;
      p.left_sample  = l;
      p.right_sample = r;
      pending_pairs.push_back(p);
   endtask

   // mostly program-like material: a level envelope with noise on top
   task automatic add_random_pairs(input int count);
      int level;
      int l, r;
      level = $urandom_range(0, 8388607);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 15) == 0) level = $urandom_range(0, 8388607);
         case ($urandom_range(0, 9))
            0:       add_pair(24'($urandom), 24'($urandom));
            1:       add_pair(24'($urandom_range(0, 255)), 24'(-$urandom_range(0, 255)));
            default: begin
               l = $urandom_range(0, level);
               r = $urandom_range(0, level);
               add_pair($urandom_range(0, 1) ? 24'(l) : 24'(-l),
                        $urandom_range(0, 1) ? 24'(r) : 24'(-r));
            end
         endcase
      end
   endtask

   task automatic random_settings();
      write_reg(CSR_THRESHOLD,   $urandom_range(838861, 16777216));
      write_reg(CSR_MAKEUP_GAIN, $urandom_range(65536, 1310720));
      write_reg(CSR_RELEASE,     $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 30000000));
      write_reg(CSR_FASTEST,     $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 30000000));
      write_reg(CSR_MU_BLEND,    $urandom_range(0, 65536));
      write_reg(CSR_MU_SQUARE,   $urandom_range(0, 1));
      write_reg(CSR_OUT_GAIN,    $urandom_range(0, 65536));
   endtask

   initial begin
      p_thr = ONE_Q24; p_makeup = 65536; p_release = 12325632; p_fastest = 14380000;
      p_blend = 65536; p_square = 1; p_ogain = 65536;
      p_speed = SPEED_RESET; p_coeff = ONE_Q30;
      for (int i = 0; i <= 1024; i++)
         sine_lut[i] = 32'(quarter_sine((longint'(i) * HALF_PI_Q30) >> 10));
      fail_count = 0; cycle_count = 0; hold_cycles = 0; sent_count = 0;
      send_gap = 0; recv_gap = 0; pace_sender = 1'b0; req_taken = 1'b0;
      req_valid = 1'b0; req_data = '0; rsp_ready = 1'b0;
      csr_valid = 1'b0; csr_index = CSR_THRESHOLD; csr_data = '0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zeros, full scale both signs, one-sided, tiny, threshold edge
      add_pair(24'h000000, 24'h000000);
      add_pair(24'h7FFFFF, 24'h7FFFFF);
      add_pair(24'h800000, 24'h800000);
      add_pair(24'h7FFFFF, 24'h800000);
      add_pair(24'h000001, 24'hFFFFFF);
      add_pair(24'h800000, 24'h000000);
      add_pair(24'h000000, 24'h7FFFFF);
      add_pair(24'h400000, 24'hC00000);
      add_pair(24'h555555, 24'hAAAAAA);
      wait_idle();

      // extremes: lowest threshold, top makeup, zero speed terms, root shaping
      write_reg(CSR_THRESHOLD,   32'd838861);
      write_reg(CSR_MAKEUP_GAIN, 32'd1310720);
      write_reg(CSR_RELEASE,     32'd0);
      write_reg(CSR_FASTEST,     32'd0);
      write_reg(CSR_MU_BLEND,    32'd0);
      write_reg(CSR_MU_SQUARE,   32'd0);
      write_reg(CSR_OUT_GAIN,    32'd0);
      add_pair(24'h7FFFFF, 24'h800000);
      add_pair(24'h000000, 24'h000000);
      add_pair(24'h0CCCCC, 24'hF33334);
      wait_idle();

      // large speed terms drive the speed into saturation; field tops above 1.0
      write_reg(CSR_RELEASE,     32'hFFFFFFFF);
      write_reg(CSR_FASTEST,     32'hFFFFFFFF);
      write_reg(CSR_MU_BLEND,    32'h1FFFF);
      write_reg(CSR_OUT_GAIN,    32'h1FFFF);
      write_reg(CSR_THRESHOLD,   32'h1FFFFFF);
      write_reg(CSR_MAKEUP_GAIN, 32'h1FFFFF);
      write_reg(CSR_MU_SQUARE,   32'd1);
      add_pair(24'h7FFFFF, 24'h7FFFFF);
      add_pair(24'h123456, 24'hEDCBAA);
      add_pair(24'h000000, 24'h000001);
      wait_idle();

      // random phases under changing settings
      pace_sender = 1'b1;
      for (int phase = 0; phase < 6; phase++) begin
         random_settings();
         if (phase == 2) begin
            // receiver stalls long while the sender keeps offering
            hold_cycles = 3000;
         end
         if (phase == 4) pace_sender = 1'b0;
         if (phase == 5) pace_sender = 1'b1;
         add_random_pairs(205);
         wait_idle();
      end

      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
